[rtl/core/csc_pkg.sv]
// ----------------------------------------------------------------------------
// csc_pkg: shared types and constants for the complete subgraph check
// Operation codes, sequencer states and graph size limits.
// ----------------------------------------------------------------------------
package csc_pkg;

  // Largest vertex count held by the adjacency store
  localparam int unsigned MaxVertices = 64;
  // Width of a vertex number on the ports
  localparam int unsigned VertW = 6;
  // Width of a row of the adjacency store and of the subset mask
  localparam int unsigned RowW = 64;
  // Walk counter width: must hold MaxVertices itself
  localparam int unsigned CntW = $clog2(MaxVertices + 1);

  typedef enum logic [2:0] {
    OpClearEdges  = 3'd0,
    OpAddEdge     = 3'd1,
    OpClearSubset = 3'd2,
    OpAddVertex   = 3'd3,
    OpCheck       = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    StIdle,
    StEdgeWrA,
    StEdgeWrB,
    StCheck
  } state_e;

endpackage

[rtl/core/complete_subgraph_check.sv]
// ----------------------------------------------------------------------------
// complete_subgraph_check: clique test on a stored undirected graph
// Keeps a symmetric adjacency bit matrix in a row memory and a vertex subset
// in a mask register; a check walks one row per cycle against the mask.
// ----------------------------------------------------------------------------
//
//  channel   | signals                                       | direction
//  ----------+-----------------------------------------------+----------
//  command   | start_i, busy_o, operation_i, vertex_a_i/b_i  | in
//  result    | done_o, is_complete_o                         | out
//
//  Clear edges, clear subset and add subset vertex complete in the accept
//  cycle. Add edge is a read-modify-write of two rows through the read and
//  write ports. A check reads one row per cycle through the read port;
//  done_o pulses in the cycle in which busy_o falls. Reset clears the row
//  valid bits, so every row reads as empty at once. The receiver cannot
//  stall; a result is shown once.
//
module complete_subgraph_check (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  output logic                      busy_o,
  input  logic [2:0]                operation_i,
  input  logic [csc_pkg::VertW-1:0] vertex_a_i,
  input  logic [csc_pkg::VertW-1:0] vertex_b_i,
  output logic                      done_o,
  output logic                      is_complete_o
);

  localparam int unsigned RowW  = csc_pkg::RowW;
  localparam int unsigned VertW = csc_pkg::VertW;
  localparam int unsigned CntW  = csc_pkg::CntW;
  localparam int unsigned Depth = csc_pkg::MaxVertices;
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1;

  // Sequencer and item registers
  csc_pkg::state_e  state_q, state_d;
  logic [VertW-1:0] va_q, va_d;
  logic [VertW-1:0] vb_q, vb_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             pend_q, pend_d;
  logic [AddrW-1:0] pidx_q, pidx_d;
  logic             ok_q, ok_d;
  logic             done_q, done_d;
  logic             res_q, res_d;

  // Stores
  logic [RowW-1:0]  mask_q, mask_d;
  logic [Depth-1:0] row_vld_q, row_vld_d;
  logic [RowW-1:0]  mem [Depth];
  logic [RowW-1:0]  rd_data_q;
  logic             rd_vld_q;

  // Memory port controls
  logic [AddrW-1:0] rd_addr;
  logic             wr_en;
  logic [AddrW-1:0] wr_addr;
  logic [RowW-1:0]  wr_data;

  logic             accept;
  logic             a_ok, b_ok;
  logic [RowW-1:0]  row;
  logic [RowW-1:0]  pbit;
  logic             fail;

  assign accept = start_i & ~busy_o;
  assign busy_o = (state_q != csc_pkg::StIdle);
  assign done_o = done_q;
  assign is_complete_o = res_q;

  // Vertices beyond the graph size are ignored
  assign a_ok = ({1'b0, vertex_a_i} < (VertW + 1)'(Depth));
  assign b_ok = ({1'b0, vertex_b_i} < (VertW + 1)'(Depth));

  // Row as read: an invalid row is empty
  assign row  = rd_vld_q ? rd_data_q : '0;
  assign pbit = RowW'(1) << pidx_q;
  // Subset member whose row misses another member
  assign fail = pend_q & mask_q[pidx_q] & (((row | pbit) & mask_q) != mask_q);

  // Next state, stores and memory port
  always_comb begin
    state_d   = state_q;
    va_d      = va_q;
    vb_d      = vb_q;
    cnt_d     = cnt_q;
    pend_d    = 1'b0;
    pidx_d    = pidx_q;
    ok_d      = ok_q;
    done_d    = 1'b0;
    res_d     = res_q;
    mask_d    = mask_q;
    row_vld_d = row_vld_q;
    rd_addr   = AddrW'(vertex_a_i);
    wr_en     = 1'b0;
    wr_addr   = AddrW'(va_q);
    wr_data   = row | (RowW'(1) << vb_q);

    case (state_q)
      csc_pkg::StIdle: begin
        if (accept) begin
          va_d = vertex_a_i;
          vb_d = vertex_b_i;
          case (csc_pkg::op_e'(operation_i))
            csc_pkg::OpClearEdges: begin
              row_vld_d = '0;
            end
            csc_pkg::OpAddEdge: begin
              // read row a now, written back next cycle
              if (a_ok && b_ok && (vertex_a_i != vertex_b_i)) begin
                state_d = csc_pkg::StEdgeWrA;
              end
            end
            csc_pkg::OpClearSubset: begin
              mask_d = '0;
            end
            csc_pkg::OpAddVertex: begin
              if (a_ok) begin
                mask_d = mask_q | (RowW'(1) << vertex_a_i);
              end
            end
            csc_pkg::OpCheck: begin
              cnt_d   = '0;
              ok_d    = 1'b1;
              state_d = csc_pkg::StCheck;
            end
            default: ;
          endcase
        end
      end
      csc_pkg::StEdgeWrA: begin
        // row a gets bit b; row b is read in the same cycle
        wr_en        = 1'b1;
        wr_addr      = AddrW'(va_q);
        wr_data      = row | (RowW'(1) << vb_q);
        row_vld_d[wr_addr] = 1'b1;
        rd_addr      = AddrW'(vb_q);
        state_d      = csc_pkg::StEdgeWrB;
      end
      csc_pkg::StEdgeWrB: begin
        wr_en        = 1'b1;
        wr_addr      = AddrW'(vb_q);
        wr_data      = row | (RowW'(1) << va_q);
        row_vld_d[wr_addr] = 1'b1;
        state_d      = csc_pkg::StIdle;
      end
      csc_pkg::StCheck: begin
        // issue one row read per cycle, compare the previous one
        rd_addr = cnt_q[AddrW-1:0];
        ok_d    = ok_q & ~fail;
        if (cnt_q != CntW'(Depth)) begin
          pend_d = 1'b1;
          pidx_d = cnt_q[AddrW-1:0];
          cnt_d  = cnt_q + CntW'(1);
        end else if (!pend_q) begin
          done_d  = 1'b1;
          res_d   = ok_q;
          state_d = csc_pkg::StIdle;
        end
      end
      default: begin
        state_d = csc_pkg::StIdle;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= csc_pkg::StIdle;
      cnt_q     <= '0;
      pend_q    <= 1'b0;
      ok_q      <= 1'b0;
      done_q    <= 1'b0;
      mask_q    <= '0;
      row_vld_q <= '0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      pend_q    <= pend_d;
      ok_q      <= ok_d;
      done_q    <= done_d;
      mask_q    <= mask_d;
      row_vld_q <= row_vld_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    va_q   <= va_d;
    vb_q   <= vb_d;
    pidx_q <= pidx_d;
    res_q  <= res_d;
  end

  // Adjacency row memory: one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_q <= mem[rd_addr];
    rd_vld_q  <= row_vld_q[rd_addr];
  end

endmodule

[tb/complete_subgraph_check_checker.sv]
// ----------------------------------------------------------------------------
// complete_subgraph_check_checker: result checker for the clique test block
// Watches the command and result channels, keeps its own copy of the
// adjacency matrix and subset mask, predicts the answer to every check and
// compares each done_o pulse with the oldest outstanding answer.
// ----------------------------------------------------------------------------
module complete_subgraph_check_checker
  import csc_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic             busy_o,
  input  logic [2:0]       operation_i,
  input  logic [VertW-1:0] vertex_a_i,
  input  logic [VertW-1:0] vertex_b_i,
  input  logic             done_o,
  input  logic             is_complete_o,
  output int unsigned      mismatch_count_o,
  output int unsigned      pending_count_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // Shadow graph and subset
  logic [RowW-1:0] graph_rows [MaxVertices];
  logic [RowW-1:0] member_mask;
  // Answers owed by checks already accepted, oldest first
  logic            owed_answers [$];

  // Every member's row, with its own bit added, must cover the whole mask
  function automatic logic subset_is_clique();
    logic [RowW-1:0] own;
    for (int v = 0; v < MaxVertices; v++) begin
      own = RowW'(1) << v;
      if ((member_mask & own) != '0 &&
          ((graph_rows[v] | own) & member_mask) != member_mask) begin
        return 1'b0;
      end
    end
    return 1'b1;
  endfunction

  function automatic logic vertex_in_range(logic [VertW-1:0] v);
    return 32'(v) < MaxVertices;
  endfunction

  task automatic report_mismatch(string what);
    if (mismatch_count_o < 10) begin
      $display("%0t: %s", $realtime, what);
    end
    mismatch_count_o <= mismatch_count_o + 1;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < MaxVertices; r++) graph_rows[r] = '0;
      member_mask = '0;
      owed_answers.delete();
      mismatch_count_o <= 0;
      pending_count_o  <= 0;
    end else begin
      // result side: one pulse per check
      if (done_o) begin
        if (owed_answers.size() == 0) begin
          report_mismatch($sformatf("unexpected result is_complete_o=%0b", is_complete_o));
        end else if (owed_answers[0] !== is_complete_o) begin
          report_mismatch($sformatf("is_complete_o: expected %0b, got %0b",
                                    owed_answers[0], is_complete_o));
          void'(owed_answers.pop_front());
        end else begin
          void'(owed_answers.pop_front());
        end
      end

      // command side: update the shadow state for each accepted item
      if (start_i && !busy_o) begin
        case (operation_i)
          OpClearEdges: begin
            for (int r = 0; r < MaxVertices; r++) graph_rows[r] = '0;
          end
          OpAddEdge: begin
            // self-loops and out-of-range endpoints leave the graph alone
            if (vertex_in_range(vertex_a_i) && vertex_in_range(vertex_b_i) &&
                vertex_a_i != vertex_b_i) begin
              graph_rows[vertex_a_i][vertex_b_i] = 1'b1;
              graph_rows[vertex_b_i][vertex_a_i] = 1'b1;
            end
          end
          OpClearSubset: member_mask = '0;
          OpAddVertex: begin
            if (vertex_in_range(vertex_a_i)) member_mask[vertex_a_i] = 1'b1;
          end
          OpCheck: owed_answers.push_back(subset_is_clique());
          default: ;  // unused codes: no effect
        endcase
      end

      pending_count_o <= owed_answers.size();
    end
  end

endmodule

[tb/complete_subgraph_check_test.sv]
// ----------------------------------------------------------------------------
// complete_subgraph_check_test: testbench top for the clique test block
// Drives directed items covering empty, single and broken subsets, then
// random clique-building sequences mixed with noise, with random gaps.
// ----------------------------------------------------------------------------
module complete_subgraph_check_test;
  timeunit 1ns;
  timeprecision 1ps;
  import csc_pkg::*;

  // Codes the block has no operation for
  localparam logic [2:0] OpUnusedLo = 3'd5;
  localparam logic [2:0] OpUnusedHi = 3'd7;

  localparam int unsigned RandomItems   = 1800;
  localparam int unsigned DrainCycles   = 2 * MaxVertices + 8;
  localparam int unsigned WatchdogLimit = 2000;

  logic             clk_i;
  logic             rst_ni;
  logic             start_i;
  logic             busy_o;
  logic [2:0]       operation_i;
  logic [VertW-1:0] vertex_a_i;
  logic [VertW-1:0] vertex_b_i;
  logic             done_o;
  logic             is_complete_o;
  int unsigned      mismatch_count;
  int unsigned      pending_count;

  int unsigned      item_count;
  int unsigned      quiet_cycles;
  bit               burst_mode;

  complete_subgraph_check u_dut (
    .clk_i,
    .rst_ni,
    .start_i,
    .busy_o,
    .operation_i,
    .vertex_a_i,
    .vertex_b_i,
    .done_o,
    .is_complete_o
  );

  complete_subgraph_check_checker u_checker (
    .clk_i,
    .rst_ni,
    .start_i,
    .busy_o,
    .operation_i,
    .vertex_a_i,
    .vertex_b_i,
    .done_o,
    .is_complete_o,
    .mismatch_count_o (mismatch_count),
    .pending_count_o  (pending_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Watchdog: stop a run in which nothing moves for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (start_i && !busy_o) || done_o) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WatchdogLimit) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // Present one item after a random gap and hold it until accepted
  task automatic send_item(logic [2:0] op, logic [VertW-1:0] a, logic [VertW-1:0] b);
    int unsigned gap;
    gap = burst_mode ? 0 : $urandom_range(0, 12);
    repeat (gap) begin
      @(negedge clk_i);
      start_i <= 1'b0;
    end
    @(negedge clk_i);
    start_i     <= 1'b1;
    operation_i <= op;
    vertex_a_i  <= a;
    vertex_b_i  <= b;
    do @(posedge clk_i); while (busy_o);
    if (op <= OpCheck) item_count++;
  endtask

  function automatic logic [VertW-1:0] rand_vertex();
    return VertW'($urandom_range(0, MaxVertices - 1));
  endfunction

  // Build a (possibly broken) clique in a window of vertices, load it as the
  // subset and ask for a check
  task automatic run_clique_sequence();
    logic [VertW-1:0] members [8];
    int unsigned      span;
    int unsigned      base;
    int unsigned      size;
    int               drop_pair;
    int               pair_idx;
    span = 4 << $urandom_range(0, 4);
    base = $urandom_range(0, MaxVertices - span);
    size = $urandom_range(0, 7);
    drop_pair = ($urandom_range(0, 2) == 0) ? $urandom_range(0, size * size / 2) : -1;
    pair_idx = 0;
    for (int i = 0; i < size; i++) begin
      members[i] = VertW'(base + $urandom_range(0, span - 1));
    end
    for (int i = 0; i < size; i++) begin
      for (int j = i + 1; j < size; j++) begin
        if (pair_idx != drop_pair) begin
          if ($urandom_range(0, 1)) send_item(OpAddEdge, members[i], members[j]);
          else                      send_item(OpAddEdge, members[j], members[i]);
        end
        pair_idx++;
      end
    end
    if ($urandom_range(0, 3) != 0) send_item(OpClearSubset, rand_vertex(), rand_vertex());
    for (int i = 0; i < size; i++) begin
      send_item(OpAddVertex, members[i], rand_vertex());
    end
    send_item(OpCheck, rand_vertex(), rand_vertex());
  endtask

  initial begin
    int unsigned pick;
    rst_ni       = 1'b0;
    start_i      = 1'b0;
    operation_i  = OpClearEdges;
    vertex_a_i   = '0;
    vertex_b_i   = '0;
    item_count   = 0;
    burst_mode   = 1'b0;
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: empty and single subsets, extremes, duplicates, self-loop,
    // ignored codes and both clears
    send_item(OpCheck, '0, '0);
    send_item(OpAddVertex, 6'd63, 6'd63);
    send_item(OpCheck, 6'd63, '0);
    send_item(OpAddVertex, '0, 6'd63);
    send_item(OpCheck, '0, '0);
    send_item(OpAddEdge, '0, 6'd63);
    send_item(OpCheck, '0, '0);
    send_item(OpAddEdge, 6'd63, '0);
    send_item(OpAddVertex, '0, '0);
    send_item(OpCheck, 6'd63, 6'd63);
    send_item(OpAddEdge, 6'd21, 6'd21);
    send_item(OpAddVertex, 6'd21, 6'd42);
    send_item(OpCheck, '0, '0);
    send_item(OpAddEdge, 6'd21, 6'd63);
    send_item(OpAddEdge, '0, 6'd21);
    send_item(OpCheck, '0, '0);
    send_item(OpUnusedLo, 6'd63, 6'd63);
    send_item(OpUnusedLo + 3'd1, 6'd42, 6'd21);
    send_item(OpUnusedHi, '0, 6'd63);
    send_item(OpCheck, 6'd42, 6'd21);
    send_item(OpClearEdges, 6'd63, 6'd63);
    send_item(OpCheck, '0, '0);
    send_item(OpClearSubset, 6'd63, '0);
    send_item(OpCheck, '0, '0);

    // Random: mostly clique sequences, some noise
    item_count = 0;
    while (item_count < RandomItems) begin
      burst_mode = ($urandom_range(0, 3) == 0);
      pick = $urandom_range(0, 9);
      if (pick <= 5) begin
        run_clique_sequence();
      end else if (pick <= 7) begin
        repeat ($urandom_range(1, 6)) begin
          send_item(3'($urandom_range(0, 7)), rand_vertex(), rand_vertex());
        end
      end else if (pick == 8) begin
        send_item(OpClearEdges, rand_vertex(), rand_vertex());
        send_item(OpCheck, rand_vertex(), rand_vertex());
      end else begin
        if ($urandom_range(0, 1)) send_item(OpClearSubset, rand_vertex(), rand_vertex());
        repeat ($urandom_range(1, 4)) send_item(OpAddVertex, rand_vertex(), rand_vertex());
        send_item(OpCheck, rand_vertex(), rand_vertex());
      end
    end

    // Drain: wait for outstanding answers, then let any stray pulse show
    @(negedge clk_i);
    start_i <= 1'b0;
    wait (pending_count == 0);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
